>>> rtl/sse_pkg.sv
`default_nettype none

package sse_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int KEY_W        = 32;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 3;
    localparam int CNT_OUT_W    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STS_INSERTED   = 3'd0,
        STS_DUPLICATE  = 3'd1,
        STS_DELETED    = 3'd2,
        STS_DEL_MISSING = 3'd3,
        STS_FOUND      = 3'd4,
        STS_NOT_FOUND  = 3'd5,
        STS_FULL       = 3'd6
    } t_status;

    // what the traveling token is doing as it passes a cell
    typedef enum logic [1:0] {
        MD_SEEK,
        MD_INS_SHIFT,
        MD_DEL_SHIFT,
        MD_DONE
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic                    vld;
        t_mode                   mode;
        logic                    is_ins;
        logic                    is_del;
        logic                    full;
        logic                    hit;
        logic signed [KEY_W-1:0] data;
    } t_tok;

endpackage

`default_nettype wire

>>> rtl/sse_req_if.sv
`default_nettype none

interface sse_req_if import sse_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic signed [KEY_W-1:0] key_value;

    modport source (output valid, output operation, output key_value, input ready);
    modport sink   (input valid, input operation, input key_value, output ready);
endinterface

`default_nettype wire

>>> rtl/sse_rsp_if.sv
`default_nettype none

interface sse_rsp_if import sse_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [CNT_OUT_W-1:0] entry_count;

    modport source (output valid, output status, output entry_count, input ready);
    modport sink   (input valid, input status, input entry_count, output ready);
endinterface

`default_nettype wire

>>> rtl/sse_cell.sv
`default_nettype none

module sse_cell import sse_pkg::*; #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [CNT_W-1:0]        i_count,
    input  wire t_tok                    i_tok,
    input  wire logic signed [KEY_W-1:0] i_next_entry,
    output t_tok                         o_tok,
    output logic signed [KEY_W-1:0]      o_entry
);

    logic signed [KEY_W-1:0] r_entry;
    logic signed [KEY_W-1:0] n_entry;
    t_tok                    r_tok;
    t_tok                    n_tok;
    logic                    w_occ;

    assign w_occ = (CNT_W'(IDX) < i_count);

    always_comb begin
        n_entry = r_entry;
        n_tok   = i_tok;
        if (i_tok.vld) begin
            unique case (i_tok.mode)
                MD_SEEK: begin
                    if (w_occ) begin
                        if (r_entry == i_tok.data) begin
                            n_tok.hit = 1'b1;
                            if (i_tok.is_del) begin
                                n_entry    = i_next_entry;
                                n_tok.mode = MD_DEL_SHIFT;
                            end else begin
                                n_tok.mode = MD_DONE;
                            end
                        end else if ($signed(r_entry) > $signed(i_tok.data)) begin
                            // key belongs here, push the old entry down the row
                            if (i_tok.is_ins && !i_tok.full) begin
                                n_entry    = i_tok.data;
                                n_tok.data = r_entry;
                                n_tok.mode = MD_INS_SHIFT;
                            end else begin
                                n_tok.mode = MD_DONE;
                            end
                        end
                    end else begin
                        // end of held values, key is larger than all of them
                        if (i_tok.is_ins && !i_tok.full) begin
                            n_entry = i_tok.data;
                        end
                        n_tok.mode = MD_DONE;
                    end
                end
                MD_INS_SHIFT: begin
                    n_entry    = i_tok.data;
                    n_tok.data = r_entry;
                    if (!w_occ) begin
                        n_tok.mode = MD_DONE;
                    end
                end
                MD_DEL_SHIFT: begin
                    if (w_occ) begin
                        n_entry = i_next_entry;
                    end else begin
                        n_tok.mode = MD_DONE;
                    end
                end
                MD_DONE: begin
                    n_tok.mode = MD_DONE;
                end
                default: begin
                    n_tok.mode = MD_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok   = r_tok;
    assign o_entry = r_entry;

endmodule

`default_nettype wire

>>> rtl/sorted_set_engine_unit.sv
`default_nettype none

// channel   dir  payload                    transaction
// i_req     in   operation, key_value       valid && ready
// o_rsp     out  status, entry_count        valid && ready
//
// every request travels as a token down a row of CAPACITY cells, one cell per cycle
// the result is registered once the token leaves the last cell; no new request is taken
// until the result is loaded into the output register, so one request is in flight at a time
// a finished result that cannot be loaded waits in a hold register and stalls i_req
// synchronous reset clears the count, the state and the tokens; cell values stay
// undefined until written

module sorted_set_engine_unit import sse_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sse_req_if.sink   i_req,
    sse_rsp_if.source o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state               r_state;
    t_state               n_state;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_out_vld;
    logic                 n_out_vld;
    t_status              r_out_status;
    t_status              n_out_status;
    logic [CNT_W-1:0]     r_out_cnt;
    logic [CNT_W-1:0]     n_out_cnt;
    t_status              r_hold_status;
    t_status              n_hold_status;

    t_tok                    w_tok [CAPACITY+1];
    logic signed [KEY_W-1:0] w_entry [CAPACITY];
    logic                    w_accept;
    logic                    w_taken;
    logic                    w_exit;
    logic                    w_grow;
    logic                    w_shrink;
    t_status                 w_status;
    logic [CNT_W-1:0]        w_new_count;
    t_tok                    w_exit_tok;

    assign w_accept = i_req.valid && i_req.ready;
    assign w_taken  = r_out_vld && o_rsp.ready;

    always_comb begin
        w_tok[0]        = '0;
        w_tok[0].vld    = w_accept;
        w_tok[0].mode   = MD_SEEK;
        w_tok[0].is_ins = (i_req.operation == OP_INSERT);
        w_tok[0].is_del = (i_req.operation == OP_DELETE);
        w_tok[0].full   = (i_req.operation == OP_INSERT) && (r_count == CNT_W'(CAPACITY));
        w_tok[0].hit    = 1'b0;
        w_tok[0].data   = i_req.key_value;
    end

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic signed [KEY_W-1:0] w_next;
        if (gi == CAPACITY - 1) begin : g_last
            assign w_next = w_entry[gi];
        end else begin : g_mid
            assign w_next = w_entry[gi+1];
        end
        sse_cell #(
            .IDX   (gi),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_count      (r_count),
            .i_tok        (w_tok[gi]),
            .i_next_entry (w_next),
            .o_tok        (w_tok[gi+1]),
            .o_entry      (w_entry[gi])
        );
    end

    assign w_exit_tok = w_tok[CAPACITY];
    assign w_exit     = w_exit_tok.vld;
    assign w_grow     = w_exit_tok.is_ins && !w_exit_tok.hit && !w_exit_tok.full;
    assign w_shrink   = w_exit_tok.is_del && w_exit_tok.hit;

    always_comb begin
        if (w_exit_tok.is_ins) begin
            if (w_exit_tok.hit) begin
                w_status = STS_DUPLICATE;
            end else if (w_exit_tok.full) begin
                w_status = STS_FULL;
            end else begin
                w_status = STS_INSERTED;
            end
        end else if (w_exit_tok.is_del) begin
            w_status = w_exit_tok.hit ? STS_DELETED : STS_DEL_MISSING;
        end else begin
            w_status = w_exit_tok.hit ? STS_FOUND : STS_NOT_FOUND;
        end

        if (w_grow) begin
            w_new_count = r_count + 1'b1;
        end else if (w_shrink) begin
            w_new_count = r_count - 1'b1;
        end else begin
            w_new_count = r_count;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_out_vld     = r_out_vld && !w_taken;
        n_out_status  = r_out_status;
        n_out_cnt     = r_out_cnt;
        n_hold_status = r_hold_status;
        i_req.ready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (w_accept) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_exit) begin
                    n_count = w_new_count;
                    if (!r_out_vld || w_taken) begin
                        n_out_vld    = 1'b1;
                        n_out_status = w_status;
                        n_out_cnt    = w_new_count;
                        n_state      = S_IDLE;
                    end else begin
                        n_hold_status = w_status;
                        n_state       = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (w_taken) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_hold_status;
                    n_out_cnt    = r_count;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out_status  <= n_out_status;
        r_out_cnt     <= n_out_cnt;
        r_hold_status <= n_hold_status;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_count = CNT_OUT_W'(r_out_cnt);

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("held count above capacity");

    a_exit_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit |-> r_state == S_RUN)
        else $error("token left the row with no request in flight");

    a_grow_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exit && w_grow) |=> r_count == CNT_W'($past(r_count) + 1'b1))
        else $error("insert did not raise the count");

    a_hold_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_HOLD |-> r_out_vld)
        else $error("result held while output register empty");

    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exit && w_exit_tok.full) |-> !w_grow && r_count == CNT_W'(CAPACITY))
        else $error("insert into a full set changed the count");
`endif

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sse_pkg::*;

    // unused selector, the block treats it as a search
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 1200;
    localparam int POOL_SIZE = 24;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PATTERN
    } t_rx_mode;

    typedef struct {
        t_status              status;
        logic [CNT_OUT_W-1:0] count;
    } t_lookup_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sse_req_if req_ch ();
    sse_rsp_if rsp_ch ();

    sorted_set_engine_unit #(
        .CAPACITY(DEF_CAPACITY)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    always #6 i_clk = ~i_clk;

    // shadow copy of the set, kept in ascending order
    logic signed [KEY_W-1:0] set_shadow[$];
    t_lookup_result          pending_results[$];
    logic signed [KEY_W-1:0] key_pool[POOL_SIZE];

    int       err_count = 0;
    int       idle_cycles = 0;
    int       rx_hold = 0;
    int       rx_tick = 0;
    t_rx_mode rx_mode = RX_OPEN;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    // applies one request to the shadow set and queues the result it must give
    function automatic void apply_to_set(input logic [OP_W-1:0] op,
                                         input logic signed [KEY_W-1:0] key);
        int             pos;
        bit             present;
        t_lookup_result res;
        pos = set_shadow.size();
        for (int i = 0; i < set_shadow.size(); i++) begin
            if (!(set_shadow[i] < key)) begin
                pos = i;
                break;
            end
        end
        present = (pos < set_shadow.size()) && (set_shadow[pos] == key);
        case (op)
            OP_INSERT: begin
                if (present) begin
                    res.status = STS_DUPLICATE;
                end else if (set_shadow.size() >= DEF_CAPACITY) begin
                    res.status = STS_FULL;
                end else begin
                    set_shadow.insert(pos, key);
                    res.status = STS_INSERTED;
                end
            end
            OP_DELETE: begin
                if (present) begin
                    set_shadow.delete(pos);
                    res.status = STS_DELETED;
                end else begin
                    res.status = STS_DEL_MISSING;
                end
            end
            default: begin
                res.status = present ? STS_FOUND : STS_NOT_FOUND;
            end
        endcase
        res.count = CNT_OUT_W'(set_shadow.size());
        pending_results.push_back(res);
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic push_request(input logic [OP_W-1:0] op,
                                input logic signed [KEY_W-1:0] key);
        req_ch.valid = 1'b1;
        req_ch.operation = op;
        req_ch.key_value = key;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        apply_to_set(op, key);
        @(negedge i_clk);
    endtask

    task automatic pause_sender(input int cycles);
        req_ch.valid = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // mostly held values or pool values, now and then anything at all
    function automatic logic signed [KEY_W-1:0] pick_key(input bit prefer_held);
        if (prefer_held && set_shadow.size() > 0 && $urandom_range(0, 1) == 1)
            return set_shadow[$urandom_range(0, set_shadow.size() - 1)];
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    task automatic test_empty_set();
        push_request(OP_SEARCH, 32'sd0);
        push_request(OP_DELETE, KEY_MIN);
        push_request(OP_SPARE, KEY_MAX);
        push_request(OP_INSERT, KEY_MAX);
        push_request(OP_INSERT, KEY_MIN);
        push_request(OP_INSERT, -32'sd1);
        push_request(OP_INSERT, 32'sd0);
        push_request(OP_INSERT, KEY_MAX);
        push_request(OP_SEARCH, KEY_MIN);
        push_request(OP_DELETE, 32'sd0);
        push_request(OP_DELETE, 32'sd0);
    endtask

    task automatic test_fill_to_capacity();
        int k;
        k = 0;
        while (set_shadow.size() < DEF_CAPACITY) begin
            push_request(OP_INSERT, 32'sd1000 - k * 32'sd377);
            k++;
        end
        push_request(OP_INSERT, 32'sd5);
        push_request(OP_INSERT, KEY_MAX);
        push_request(OP_SPARE, 32'sd1000);
        push_request(OP_DELETE, 32'sd6);
        push_request(OP_DELETE, KEY_MIN);
        push_request(OP_INSERT, 32'sd5);
    endtask

    // receiver stops while the sender keeps offering, so the block backs up
    task automatic test_output_stall();
        pause_sender(1);
        rx_hold = HOLD_CYCLES;
        for (int i = 0; i < 20; i++)
            push_request(t_op'($urandom_range(0, 2)), pick_key(1'b1));
        pause_sender(1);
    endtask

    task automatic test_random_traffic();
        bit             growing;
        int             phase_left;
        int             burst_left;
        int             r;
        logic [OP_W-1:0] op;
        growing = 1'b1;
        phase_left = 50;
        burst_left = 10;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0)
                rx_mode = t_rx_mode'((n / 150) % 4);
            if (phase_left == 0) begin
                growing = !growing;
                phase_left = $urandom_range(30, 80);
            end
            phase_left--;
            r = $urandom_range(0, 99);
            if (growing)
                op = (r < 55) ? OP_INSERT : (r < 75) ? OP_DELETE :
                     (r < 95) ? OP_SEARCH : OP_SPARE;
            else
                op = (r < 20) ? OP_INSERT : (r < 70) ? OP_DELETE :
                     (r < 95) ? OP_SEARCH : OP_SPARE;
            push_request(op, pick_key(op != OP_INSERT || !growing));
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                pause_sender($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 25));
            end else begin
                burst_left--;
            end
        end
        pause_sender(1);
        rx_mode = RX_OPEN;
    endtask

    // response side ready pattern, driven at the falling edge
    always @(negedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:    rsp_ch.ready <= 1'b1;
                RX_COIN:    rsp_ch.ready <= $urandom_range(0, 1);
                RX_SPARSE:  rsp_ch.ready <= ($urandom_range(0, 7) != 0);
                RX_PATTERN: rsp_ch.ready <= ((rx_tick % 23) < 13);
                default:    rsp_ch.ready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with none expected: status %0d count %0d",
                                          rsp_ch.status, rsp_ch.entry_count));
            end else begin
                if (rsp_ch.status !== pending_results[0].status)
                    report_mismatch($sformatf("status %0d, expected %s", rsp_ch.status,
                                              pending_results[0].status.name()));
                if (rsp_ch.entry_count !== pending_results[0].count)
                    report_mismatch($sformatf("entry_count %0d, expected %0d",
                                              rsp_ch.entry_count, pending_results[0].count));
                void'(pending_results.pop_front());
            end
        end
    end

    // counts cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("stalled for %0d cycles with %0d results outstanding",
                     idle_cycles, pending_results.size());
            $display("tb_top: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.operation = OP_INSERT;
        req_ch.key_value = '0;
        rsp_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = 32'sd0;
        key_pool[3] = -32'sd1;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_set();
        test_fill_to_capacity();
        test_output_stall();
        test_random_traffic();

        req_ch.valid = 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (DEF_CAPACITY + 8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
